[rtl/core/ctok_pkg.sv]
package ctok_pkg;

	// Automaton state codes, start is zero
	localparam int unsigned STATE_W = 7;
	localparam int unsigned CLASS_W = 3;

	localparam logic [STATE_W-1:0] ST_START     = 7'd0;
	localparam logic [STATE_W-1:0] ST_IDENT     = 7'd1;
	localparam logic [STATE_W-1:0] ST_INT       = 7'd2;
	localparam logic [STATE_W-1:0] ST_FDOT      = 7'd3;
	localparam logic [STATE_W-1:0] ST_FDIG      = 7'd4;
	localparam logic [STATE_W-1:0] ST_FEXP      = 7'd5;
	localparam logic [STATE_W-1:0] ST_FEXPSIGN  = 7'd6;
	localparam logic [STATE_W-1:0] ST_FEXPDIG   = 7'd7;
	localparam logic [STATE_W-1:0] ST_HEXPRE    = 7'd8;
	localparam logic [STATE_W-1:0] ST_HEXDIG    = 7'd9;
	localparam logic [STATE_W-1:0] ST_OCTDIG    = 7'd10;
	localparam logic [STATE_W-1:0] ST_BINPRE    = 7'd11;
	localparam logic [STATE_W-1:0] ST_BINDIG    = 7'd12;
	localparam logic [STATE_W-1:0] ST_STRSTART  = 7'd13;
	localparam logic [STATE_W-1:0] ST_STRBODY   = 7'd14;
	localparam logic [STATE_W-1:0] ST_STRESC    = 7'd15;
	localparam logic [STATE_W-1:0] ST_STRHEXESC = 7'd16;
	localparam logic [STATE_W-1:0] ST_STROCTESC = 7'd17;
	localparam logic [STATE_W-1:0] ST_STREND    = 7'd18;
	localparam logic [STATE_W-1:0] ST_CHSTART   = 7'd19;
	localparam logic [STATE_W-1:0] ST_CHBODY    = 7'd20;
	localparam logic [STATE_W-1:0] ST_CHESC     = 7'd21;
	localparam logic [STATE_W-1:0] ST_CHEND     = 7'd22;
	localparam logic [STATE_W-1:0] ST_PLUS      = 7'd23;
	localparam logic [STATE_W-1:0] ST_MINUS     = 7'd24;
	localparam logic [STATE_W-1:0] ST_MUL       = 7'd25;
	localparam logic [STATE_W-1:0] ST_DIV       = 7'd26;
	localparam logic [STATE_W-1:0] ST_MOD       = 7'd27;
	localparam logic [STATE_W-1:0] ST_ASSIGN    = 7'd28;
	localparam logic [STATE_W-1:0] ST_EQ        = 7'd29;
	localparam logic [STATE_W-1:0] ST_NOT       = 7'd30;
	localparam logic [STATE_W-1:0] ST_NE        = 7'd31;
	localparam logic [STATE_W-1:0] ST_LT        = 7'd32;
	localparam logic [STATE_W-1:0] ST_LE        = 7'd33;
	localparam logic [STATE_W-1:0] ST_GT        = 7'd34;
	localparam logic [STATE_W-1:0] ST_GE        = 7'd35;
	localparam logic [STATE_W-1:0] ST_LAND      = 7'd37;
	localparam logic [STATE_W-1:0] ST_LOR       = 7'd39;
	localparam logic [STATE_W-1:0] ST_BAND      = 7'd40;
	localparam logic [STATE_W-1:0] ST_BOR       = 7'd41;
	localparam logic [STATE_W-1:0] ST_BXOR      = 7'd42;
	localparam logic [STATE_W-1:0] ST_BNOT      = 7'd43;
	localparam logic [STATE_W-1:0] ST_SHL       = 7'd45;
	localparam logic [STATE_W-1:0] ST_SHR       = 7'd47;
	localparam logic [STATE_W-1:0] ST_INC       = 7'd49;
	localparam logic [STATE_W-1:0] ST_DEC       = 7'd51;
	localparam logic [STATE_W-1:0] ST_ARROW     = 7'd53;
	localparam logic [STATE_W-1:0] ST_LCOM      = 7'd55;
	localparam logic [STATE_W-1:0] ST_BCOM      = 7'd56;
	localparam logic [STATE_W-1:0] ST_BCOMEND   = 7'd57;
	localparam logic [STATE_W-1:0] ST_LPAREN    = 7'd58;
	localparam logic [STATE_W-1:0] ST_RPAREN    = 7'd59;
	localparam logic [STATE_W-1:0] ST_LBRACK    = 7'd60;
	localparam logic [STATE_W-1:0] ST_RBRACK    = 7'd61;
	localparam logic [STATE_W-1:0] ST_LBRACE    = 7'd62;
	localparam logic [STATE_W-1:0] ST_RBRACE    = 7'd63;
	localparam logic [STATE_W-1:0] ST_SEMI      = 7'd64;
	localparam logic [STATE_W-1:0] ST_COMMA     = 7'd65;
	localparam logic [STATE_W-1:0] ST_DOT       = 7'd66;
	localparam logic [STATE_W-1:0] ST_COLON     = 7'd67;
	localparam logic [STATE_W-1:0] ST_QUEST     = 7'd68;
	localparam logic [STATE_W-1:0] ST_WS        = 7'd69;
	localparam logic [STATE_W-1:0] ST_NL        = 7'd70;
	localparam logic [STATE_W-1:0] ST_EOF       = 7'd71;
	localparam logic [STATE_W-1:0] ST_ERROR     = 7'd72;
	localparam logic [STATE_W-1:0] AC_IDENT     = 7'd73;
	localparam logic [STATE_W-1:0] AC_INT       = 7'd74;
	localparam logic [STATE_W-1:0] AC_FLOAT     = 7'd75;
	localparam logic [STATE_W-1:0] AC_HEX       = 7'd76;
	localparam logic [STATE_W-1:0] AC_OCT       = 7'd77;
	localparam logic [STATE_W-1:0] AC_BIN       = 7'd78;
	localparam logic [STATE_W-1:0] AC_STR       = 7'd79;
	localparam logic [STATE_W-1:0] AC_CHAR      = 7'd80;
	localparam logic [STATE_W-1:0] AC_OP        = 7'd81;
	localparam logic [STATE_W-1:0] AC_DELIM     = 7'd82;
	localparam logic [STATE_W-1:0] AC_COMMENT   = 7'd83;
	localparam logic [STATE_W-1:0] AC_EOF       = 7'd84;

	// Token classes reported with an accept state
	localparam logic [CLASS_W-1:0] TC_NONE    = 3'd0;
	localparam logic [CLASS_W-1:0] TC_IDENT   = 3'd1;
	localparam logic [CLASS_W-1:0] TC_INTEGER = 3'd2;
	localparam logic [CLASS_W-1:0] TC_FLOAT   = 3'd3;
	localparam logic [CLASS_W-1:0] TC_STRING  = 3'd4;
	localparam logic [CLASS_W-1:0] TC_CHAR    = 3'd5;
	localparam logic [CLASS_W-1:0] TC_EOF     = 3'd6;
	localparam logic [CLASS_W-1:0] TC_COMMENT = 3'd7;

	// Byte class flags, shared between the classifier and the transition logic
	typedef struct packed {
		logic alpha;
		logic digit;
		logic hex;
		logic oct;
		logic bin;
		logic ws;
	} char_class_t;

	// Result of one step
	typedef struct packed {
		logic [STATE_W-1:0] state_code;
		logic               accepting;
		logic               is_error;
		logic [CLASS_W-1:0] token_class;
	} step_result_t;

endpackage

[rtl/core/c_token_recognizer_dfa.sv]
// Lexer automaton for a C-like language. Each slave transaction carries one source
// byte (or a restart flag in s_tuser) and yields exactly one master transaction with
// the new automaton state, its accept and error flags and the token class. One byte
// is taken per clock cycle when the output side keeps up; a byte goes through an
// input register, the next-state table and the result register, so a result is
// presented when its byte reaches the result register. The rate is set by the
// single state register that feeds back through the next-state table. The error
// state holds until restart.
module c_token_recognizer_dfa
	import ctok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic [0:0]  s_tuser,  // [0] operation (1 = restart)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] state_code, [7] zero
	output logic [4:0]  m_tuser   // [0] accepting, [1] is_error, [4:2] token_class
);

	logic               valid_s1;
	logic               op_s1;
	logic [7:0]         char_s1;
	logic [STATE_W-1:0] state_q;
	logic               valid_s2;
	step_result_t       res_s2;
	char_class_t        cls;
	step_result_t       res;
	logic               adv;

	// Advance the input stage whenever the result register is free or being drained
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	// Hold the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser[0];
			char_s1 <= s_tdata;
		end
	end

	ctok_classify u_classify (
		.char_code (char_s1),
		.cls       (cls)
	);

	ctok_next u_next (
		.cur_state (state_q),
		.restart   (op_s1),
		.char_code (char_s1),
		.cls       (cls),
		.res       (res)
	);

	// Update the automaton state as each byte moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_START;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				state_q <= res.state_code;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1)
			res_s2 <= res;
	end

	// Drive the result transaction
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.state_code};
	assign m_tuser  = {res_s2.token_class, res_s2.is_error, res_s2.accepting};

endmodule

[rtl/core/ctok_classify.sv]
module ctok_classify
	import ctok_pkg::*;
(
	input  logic [7:0]  char_code,
	output char_class_t cls
);

	logic lower;
	logic upper;

	// Decode ASCII ranges; bytes above 127 match none of them
	always_comb begin
		lower     = (char_code >= 8'h61) && (char_code <= 8'h7a);
		upper     = (char_code >= 8'h41) && (char_code <= 8'h5a);
		cls.alpha = lower || upper;
		cls.digit = (char_code >= 8'h30) && (char_code <= 8'h39);
		cls.hex   = cls.digit || ((char_code >= 8'h61) && (char_code <= 8'h66))
			|| ((char_code >= 8'h41) && (char_code <= 8'h46));
		cls.oct   = (char_code >= 8'h30) && (char_code <= 8'h37);
		cls.bin   = (char_code == 8'h30) || (char_code == 8'h31);
		cls.ws    = (char_code == 8'h20) || (char_code == 8'h09) || (char_code == 8'h0d);
	end

endmodule

[rtl/core/ctok_next.sv]
module ctok_next
	import ctok_pkg::*;
(
	input  logic [STATE_W-1:0] cur_state,
	input  logic               restart,
	input  logic [7:0]         char_code,
	input  char_class_t        cls,
	output step_result_t       res
);

	// Byte constants used by the transition rules
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_UND   = 8'h5f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7c;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_UE    = 8'h45;

	logic [STATE_W-1:0] start_nxt;
	logic [STATE_W-1:0] str_nxt;
	logic [STATE_W-1:0] nxt;

	// Dispatch from the start state
	always_comb begin
		case (char_code)
			CH_DQ:    start_nxt = ST_STRSTART;
			CH_SQ:    start_nxt = ST_CHSTART;
			CH_PLUS:  start_nxt = ST_PLUS;
			CH_MINUS: start_nxt = ST_MINUS;
			CH_STAR:  start_nxt = ST_MUL;
			CH_SLASH: start_nxt = ST_DIV;
			8'h25:    start_nxt = ST_MOD;
			CH_EQ:    start_nxt = ST_ASSIGN;
			8'h21:    start_nxt = ST_NOT;
			CH_LT:    start_nxt = ST_LT;
			CH_GT:    start_nxt = ST_GT;
			CH_AMP:   start_nxt = ST_BAND;
			CH_BAR:   start_nxt = ST_BOR;
			8'h5e:    start_nxt = ST_BXOR;
			8'h7e:    start_nxt = ST_BNOT;
			8'h28:    start_nxt = ST_LPAREN;
			8'h29:    start_nxt = ST_RPAREN;
			8'h5b:    start_nxt = ST_LBRACK;
			8'h5d:    start_nxt = ST_RBRACK;
			8'h7b:    start_nxt = ST_LBRACE;
			8'h7d:    start_nxt = ST_RBRACE;
			8'h3b:    start_nxt = ST_SEMI;
			8'h2c:    start_nxt = ST_COMMA;
			CH_DOT:   start_nxt = ST_DOT;
			8'h3a:    start_nxt = ST_COLON;
			8'h3f:    start_nxt = ST_QUEST;
			CH_NL:    start_nxt = ST_NL;
			CH_NUL:   start_nxt = ST_EOF;
			default:  start_nxt = ST_ERROR;
		endcase
		if (cls.ws)
			start_nxt = ST_WS;
		if (cls.digit)
			start_nxt = (char_code == CH_ZERO) ? ST_OCTDIG : ST_INT;
		if (cls.alpha || (char_code == CH_UND))
			start_nxt = ST_IDENT;
	end

	// String body rule, shared by the string start, body and escape-tail states
	always_comb begin
		if (char_code == CH_DQ)
			str_nxt = ST_STREND;
		else if (char_code == CH_BSL)
			str_nxt = ST_STRESC;
		else if ((char_code != CH_NL) && (char_code != CH_NUL))
			str_nxt = ST_STRBODY;
		else
			str_nxt = ST_ERROR;
	end

	// Transition table
	always_comb begin
		nxt = ST_ERROR;
		case (cur_state)
			ST_START: nxt = start_nxt;
			ST_IDENT: nxt = (cls.alpha || cls.digit || (char_code == CH_UND)) ? ST_IDENT : AC_IDENT;
			ST_INT: begin
				if (cls.digit)
					nxt = ST_INT;
				else if (char_code == CH_DOT)
					nxt = ST_FDOT;
				else if ((char_code == CH_LE) || (char_code == CH_UE))
					nxt = ST_FEXP;
				else
					nxt = AC_INT;
			end
			ST_OCTDIG: begin
				if ((char_code == CH_LX) || (char_code == CH_UX))
					nxt = ST_HEXPRE;
				else if ((char_code == CH_LB) || (char_code == CH_UB))
					nxt = ST_BINPRE;
				else if (cls.oct)
					nxt = ST_OCTDIG;
				else if (char_code == CH_DOT)
					nxt = ST_FDOT;
				else
					nxt = AC_OCT;
			end
			ST_HEXPRE: nxt = cls.hex ? ST_HEXDIG : ST_ERROR;
			ST_HEXDIG: nxt = cls.hex ? ST_HEXDIG : AC_HEX;
			ST_BINPRE: nxt = cls.bin ? ST_BINDIG : ST_ERROR;
			ST_BINDIG: nxt = cls.bin ? ST_BINDIG : AC_BIN;
			ST_FDOT:   nxt = cls.digit ? ST_FDIG : ST_ERROR;
			ST_FDIG: begin
				if (cls.digit)
					nxt = ST_FDIG;
				else if ((char_code == CH_LE) || (char_code == CH_UE))
					nxt = ST_FEXP;
				else
					nxt = AC_FLOAT;
			end
			ST_FEXP: begin
				if ((char_code == CH_PLUS) || (char_code == CH_MINUS))
					nxt = ST_FEXPSIGN;
				else
					nxt = cls.digit ? ST_FEXPDIG : ST_ERROR;
			end
			ST_FEXPSIGN: nxt = cls.digit ? ST_FEXPDIG : ST_ERROR;
			ST_FEXPDIG:  nxt = cls.digit ? ST_FEXPDIG : AC_FLOAT;
			ST_STRSTART, ST_STRBODY, ST_STRHEXESC, ST_STROCTESC: nxt = str_nxt;
			ST_STRESC: begin
				if (char_code == CH_LX)
					nxt = ST_STRHEXESC;
				else if (cls.oct)
					nxt = ST_STROCTESC;
				else
					nxt = ST_STRBODY;
			end
			ST_STREND: nxt = AC_STR;
			ST_CHSTART: begin
				if (char_code == CH_SQ)
					nxt = ST_CHEND;
				else if (char_code == CH_BSL)
					nxt = ST_CHESC;
				else if ((char_code != CH_NL) && (char_code != CH_NUL))
					nxt = ST_CHBODY;
				else
					nxt = ST_ERROR;
			end
			ST_CHBODY: nxt = (char_code == CH_SQ) ? ST_CHEND : ST_ERROR;
			ST_CHESC:  nxt = ST_CHBODY;
			ST_CHEND:  nxt = AC_CHAR;
			ST_PLUS:   nxt = (char_code == CH_PLUS) ? ST_INC : AC_OP;
			ST_MINUS: begin
				if (char_code == CH_MINUS)
					nxt = ST_DEC;
				else if (char_code == CH_GT)
					nxt = ST_ARROW;
				else
					nxt = AC_OP;
			end
			ST_DIV: begin
				if (char_code == CH_SLASH)
					nxt = ST_LCOM;
				else if (char_code == CH_STAR)
					nxt = ST_BCOM;
				else
					nxt = AC_OP;
			end
			ST_ASSIGN: nxt = (char_code == CH_EQ) ? ST_EQ : AC_OP;
			ST_NOT:    nxt = (char_code == CH_EQ) ? ST_NE : AC_OP;
			ST_LT: begin
				if (char_code == CH_EQ)
					nxt = ST_LE;
				else if (char_code == CH_LT)
					nxt = ST_SHL;
				else
					nxt = AC_OP;
			end
			ST_GT: begin
				if (char_code == CH_EQ)
					nxt = ST_GE;
				else if (char_code == CH_GT)
					nxt = ST_SHR;
				else
					nxt = AC_OP;
			end
			ST_BAND: nxt = (char_code == CH_AMP) ? ST_LAND : AC_OP;
			ST_BOR:  nxt = (char_code == CH_BAR) ? ST_LOR : AC_OP;
			ST_MUL, ST_MOD, ST_BXOR, ST_BNOT, ST_EQ, ST_NE, ST_INC, ST_DEC, ST_ARROW,
			ST_LAND, ST_LOR, ST_SHL, ST_SHR, ST_LE, ST_GE: nxt = AC_OP;
			ST_LCOM: nxt = (char_code == CH_NL) ? AC_COMMENT : ST_LCOM;
			ST_BCOM: nxt = (char_code == CH_STAR) ? ST_BCOMEND : ST_BCOM;
			ST_BCOMEND: begin
				if (char_code == CH_SLASH)
					nxt = AC_COMMENT;
				else if (char_code == CH_STAR)
					nxt = ST_BCOMEND;
				else
					nxt = ST_BCOM;
			end
			ST_LPAREN, ST_RPAREN, ST_LBRACK, ST_RBRACK, ST_LBRACE, ST_RBRACE,
			ST_SEMI, ST_COMMA, ST_DOT, ST_COLON, ST_QUEST: nxt = AC_DELIM;
			ST_WS:  nxt = cls.ws ? ST_WS : ST_START;
			ST_NL:  nxt = ST_START;
			ST_EOF: nxt = AC_EOF;
			AC_IDENT, AC_INT, AC_FLOAT, AC_HEX, AC_OCT, AC_BIN, AC_STR, AC_CHAR,
			AC_OP, AC_DELIM, AC_COMMENT, AC_EOF: nxt = ST_START;
			default: nxt = ST_ERROR;
		endcase
		if (restart)
			nxt = ST_START;
	end

	// Flags and token class of the new state
	always_comb begin
		res.state_code = nxt;
		res.accepting  = (nxt >= AC_IDENT) && (nxt <= AC_EOF);
		res.is_error   = (nxt == ST_ERROR);
		case (nxt)
			AC_IDENT:                       res.token_class = TC_IDENT;
			AC_INT, AC_HEX, AC_OCT, AC_BIN: res.token_class = TC_INTEGER;
			AC_FLOAT:                       res.token_class = TC_FLOAT;
			AC_STR:                         res.token_class = TC_STRING;
			AC_CHAR:                        res.token_class = TC_CHAR;
			AC_EOF:                         res.token_class = TC_EOF;
			AC_COMMENT:                     res.token_class = TC_COMMENT;
			default:                        res.token_class = TC_NONE;
		endcase
	end

endmodule

[sim/tb_c_token_recognizer_dfa.sv]
module tb_c_token_recognizer_dfa;
	import ctok_pkg::*;

	localparam int N_ITEMS        = 1450;
	localparam int N_DIR          = 25;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	// Control, quote and backslash bytes named for the model and the stimulus
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam step_result_t NO_CHECK = '0;

	// One row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic         restart;
		logic [7:0]   ch;
		logic         typed;
		step_result_t want;
	} lex_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [0:0] s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [4:0] m_tuser;

	logic [STATE_W-1:0] lex_state = ST_START;
	step_result_t       expected_q [$];
	logic [8:0]         text_q [$];
	lex_row_t           dir_rows [N_DIR];
	int                 errors = 0;
	int                 sent = 0;
	int                 idle_cycles = 0;
	bit                 tx_calm = 1'b0;
	bit                 long_hold_req = 1'b0;
	bit                 drain_req = 1'b0;

	c_token_recognizer_dfa DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Next automaton state for one source byte
	function automatic logic [STATE_W-1:0] next_lex_state(input logic [STATE_W-1:0] s,
			input logic [7:0] c);
		logic c_alpha, c_digit, c_hex, c_oct, c_bin, c_ws, c_exp;
		logic [STATE_W-1:0] str_next, from_start;
		c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		c_digit = c >= "0" && c <= "9";
		c_hex   = c_digit || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
		c_oct   = c >= "0" && c <= "7";
		c_bin   = c == "0" || c == "1";
		c_ws    = c == " " || c == CH_TAB || c == CH_CR;
		c_exp   = c == "e" || c == "E";
		// string body: quote ends, backslash escapes, newline or NUL is fatal
		if (c == CH_QUOTE)
			str_next = ST_STREND;
		else if (c == CH_BSLASH)
			str_next = ST_STRESC;
		else if (c != CH_LF && c != CH_NUL)
			str_next = ST_STRBODY;
		else
			str_next = ST_ERROR;
		case (c)
		CH_QUOTE:                 from_start = ST_STRSTART;
		CH_APOS:                  from_start = ST_CHSTART;
		"+":                      from_start = ST_PLUS;
		"-":                      from_start = ST_MINUS;
		"*":                      from_start = ST_MUL;
		"/":                      from_start = ST_DIV;
		"%":                      from_start = ST_MOD;
		"=":                      from_start = ST_ASSIGN;
		"!":                      from_start = ST_NOT;
		"<":                      from_start = ST_LT;
		">":                      from_start = ST_GT;
		"&":                      from_start = ST_BAND;
		"|":                      from_start = ST_BOR;
		"^":                      from_start = ST_BXOR;
		"~":                      from_start = ST_BNOT;
		"(":                      from_start = ST_LPAREN;
		")":                      from_start = ST_RPAREN;
		"[":                      from_start = ST_LBRACK;
		"]":                      from_start = ST_RBRACK;
		"{":                      from_start = ST_LBRACE;
		"}":                      from_start = ST_RBRACE;
		";":                      from_start = ST_SEMI;
		",":                      from_start = ST_COMMA;
		".":                      from_start = ST_DOT;
		":":                      from_start = ST_COLON;
		"?":                      from_start = ST_QUEST;
		" ", CH_TAB, CH_CR:       from_start = ST_WS;
		CH_LF:                    from_start = ST_NL;
		CH_NUL:                   from_start = ST_EOF;
		default:                  from_start = ST_ERROR;
		endcase
		if (c_alpha || c == "_")
			from_start = ST_IDENT;
		else if (c == "0")
			from_start = ST_OCTDIG;
		else if (c_digit)
			from_start = ST_INT;

		case (s)
		ST_START:    return from_start;
		ST_IDENT:    return (c_alpha || c_digit || c == "_") ? ST_IDENT : AC_IDENT;
		ST_INT: begin
			if (c_digit) return ST_INT;
			if (c == ".") return ST_FDOT;
			if (c_exp) return ST_FEXP;
			return AC_INT;
		end
		ST_OCTDIG: begin
			if (c == "x" || c == "X") return ST_HEXPRE;
			if (c == "b" || c == "B") return ST_BINPRE;
			if (c_oct) return ST_OCTDIG;
			if (c == ".") return ST_FDOT;
			return AC_OCT;
		end
		ST_HEXPRE:   return c_hex ? ST_HEXDIG : ST_ERROR;
		ST_HEXDIG:   return c_hex ? ST_HEXDIG : AC_HEX;
		ST_BINPRE:   return c_bin ? ST_BINDIG : ST_ERROR;
		ST_BINDIG:   return c_bin ? ST_BINDIG : AC_BIN;
		ST_FDOT:     return c_digit ? ST_FDIG : ST_ERROR;
		ST_FDIG: begin
			if (c_digit) return ST_FDIG;
			if (c_exp) return ST_FEXP;
			return AC_FLOAT;
		end
		ST_FEXP: begin
			if (c == "+" || c == "-") return ST_FEXPSIGN;
			return c_digit ? ST_FEXPDIG : ST_ERROR;
		end
		ST_FEXPSIGN: return c_digit ? ST_FEXPDIG : ST_ERROR;
		ST_FEXPDIG:  return c_digit ? ST_FEXPDIG : AC_FLOAT;
		ST_STRSTART, ST_STRBODY, ST_STRHEXESC, ST_STROCTESC:
			return str_next;
		ST_STRESC: begin
			if (c == "x") return ST_STRHEXESC;
			if (c_oct) return ST_STROCTESC;
			return ST_STRBODY;
		end
		ST_STREND:   return AC_STR;
		ST_CHSTART: begin
			if (c == CH_APOS) return ST_CHEND;
			if (c == CH_BSLASH) return ST_CHESC;
			if (c != CH_LF && c != CH_NUL) return ST_CHBODY;
			return ST_ERROR;
		end
		ST_CHBODY:   return (c == CH_APOS) ? ST_CHEND : ST_ERROR;
		ST_CHESC:    return ST_CHBODY;
		ST_CHEND:    return AC_CHAR;
		ST_PLUS:     return (c == "+") ? ST_INC : AC_OP;
		ST_MINUS: begin
			if (c == "-") return ST_DEC;
			if (c == ">") return ST_ARROW;
			return AC_OP;
		end
		ST_DIV: begin
			if (c == "/") return ST_LCOM;
			if (c == "*") return ST_BCOM;
			return AC_OP;
		end
		ST_ASSIGN:   return (c == "=") ? ST_EQ : AC_OP;
		ST_NOT:      return (c == "=") ? ST_NE : AC_OP;
		ST_LT: begin
			if (c == "=") return ST_LE;
			if (c == "<") return ST_SHL;
			return AC_OP;
		end
		ST_GT: begin
			if (c == "=") return ST_GE;
			if (c == ">") return ST_SHR;
			return AC_OP;
		end
		ST_BAND:     return (c == "&") ? ST_LAND : AC_OP;
		ST_BOR:      return (c == "|") ? ST_LOR : AC_OP;
		ST_MUL, ST_MOD, ST_BXOR, ST_BNOT, ST_EQ, ST_NE, ST_INC, ST_DEC, ST_ARROW,
		ST_LAND, ST_LOR, ST_SHL, ST_SHR, ST_LE, ST_GE:
			return AC_OP;
		ST_LCOM:     return (c == CH_LF) ? AC_COMMENT : ST_LCOM;
		ST_BCOM:     return (c == "*") ? ST_BCOMEND : ST_BCOM;
		ST_BCOMEND: begin
			if (c == "/") return AC_COMMENT;
			if (c == "*") return ST_BCOMEND;
			return ST_BCOM;
		end
		ST_LPAREN, ST_RPAREN, ST_LBRACK, ST_RBRACK, ST_LBRACE, ST_RBRACE,
		ST_SEMI, ST_COMMA, ST_DOT, ST_COLON, ST_QUEST:
			return AC_DELIM;
		ST_WS:       return c_ws ? ST_WS : ST_START;
		ST_NL:       return ST_START;
		ST_EOF:      return AC_EOF;
		AC_IDENT, AC_INT, AC_FLOAT, AC_HEX, AC_OCT, AC_BIN, AC_STR, AC_CHAR,
		AC_OP, AC_DELIM, AC_COMMENT, AC_EOF:
			return ST_START;
		default:     return ST_ERROR;
		endcase
	endfunction

	// Advance the shadow automaton by one transaction and build its result
	function automatic step_result_t lex_step(input logic restart, input logic [7:0] ch);
		step_result_t r;
		lex_state     = restart ? ST_START : next_lex_state(lex_state, ch);
		r.state_code  = lex_state;
		r.accepting   = lex_state >= AC_IDENT && lex_state <= AC_EOF;
		r.is_error    = lex_state == ST_ERROR;
		case (lex_state)
		AC_IDENT:                        r.token_class = TC_IDENT;
		AC_INT, AC_HEX, AC_OCT, AC_BIN:  r.token_class = TC_INTEGER;
		AC_FLOAT:                        r.token_class = TC_FLOAT;
		AC_STR:                          r.token_class = TC_STRING;
		AC_CHAR:                         r.token_class = TC_CHAR;
		AC_EOF:                          r.token_class = TC_EOF;
		AC_COMMENT:                      r.token_class = TC_COMMENT;
		default:                         r.token_class = TC_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pick(input string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	// Printable byte that is neither a quote, an apostrophe nor a backslash
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(32, 126));
		if (c == CH_QUOTE || c == CH_APOS || c == CH_BSLASH)
			c = "a";
		return c;
	endfunction

	function automatic void put(input logic [7:0] c);
		text_q.push_back({1'b0, c});
	endfunction

	// Append one token of random shape and content, then its separators, or else a lone restart item
	task automatic compose_token();
		logic [7:0] c;
		// leave the error state mostly at once so the stream keeps reaching deep states
		if (lex_state == ST_ERROR && $urandom_range(0, 3) != 0) begin
			c = 8'($urandom_range(0, 255));
			text_q.push_back({1'b1, c});
			return;
		end
		case ($urandom_range(0, 15))
		0: begin
			put(pick("abcxyzEXQ_"));
			repeat ($urandom_range(0, 5)) put(pick("azAZ09_ex"));
		end
		1: begin
			put(pick("123456789"));
			repeat ($urandom_range(0, 4)) put(pick("0123456789"));
		end
		2: begin
			repeat ($urandom_range(1, 3)) put(pick("0123456789"));
			if ($urandom_range(0, 3) != 0) begin
				put(".");
				repeat ($urandom_range(1, 3)) put(pick("0123456789"));
			end
			if ($urandom_range(0, 1) != 0) begin
				put(pick("eE"));
				if ($urandom_range(0, 1) != 0)
					put(pick("+-"));
				repeat ($urandom_range(1, 3)) put(pick("0123456789"));
			end
		end
		3: begin
			put("0");
			put(pick("xX"));
			repeat ($urandom_range(1, 4)) put(pick("0123456789abcdefABCDEF"));
		end
		4: begin
			put("0");
			repeat ($urandom_range(0, 3)) put(pick("01234567"));
		end
		5: begin
			put("0");
			put(pick("bB"));
			repeat ($urandom_range(1, 6)) put(pick("01"));
		end
		6: begin
			put(CH_QUOTE);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 3))
				0: begin
					c = 8'($urandom_range(128, 255));
					put(c);
				end
				1: begin
					put(CH_BSLASH);
					put(pick("nx07\\\"t"));
				end
				default: put(plain_char());
				endcase
			end
			put(CH_QUOTE);
		end
		7: begin
			put(CH_APOS);
			case ($urandom_range(0, 3))
			0: ;
			1: begin
				put(CH_BSLASH);
				put(pick("n'0\\"));
			end
			default: put(plain_char());
			endcase
			put(CH_APOS);
		end
		8: begin
			put(pick("+-*/%=!<>&|^~"));
			if ($urandom_range(0, 1) != 0)
				put(pick("+-=<>&|"));
		end
		9: put(pick("()[]{};,.:?"));
		10: begin
			put("/");
			put("/");
			repeat ($urandom_range(0, 8)) begin
				c = 8'($urandom_range(1, 255));
				put((c == CH_LF) ? "z" : c);
			end
			put(CH_LF);
		end
		11: begin
			put("/");
			put("*");
			repeat ($urandom_range(0, 8)) begin
				c = 8'($urandom_range(128, 255));
				put(($urandom_range(0, 4) == 0) ? c : pick("ab *\n/"));
			end
			repeat ($urandom_range(1, 3)) put("*");
			put("/");
		end
		12: begin
			repeat ($urandom_range(1, 4)) put(($urandom_range(0, 2) == 0) ? CH_CR : pick(" \t"));
		end
		13: put(CH_NUL);
		14: begin
			repeat ($urandom_range(1, 3)) begin
				c = 8'($urandom_range(0, 255));
				put(c);
			end
		end
		default: begin
			c = 8'($urandom_range(0, 255));
			text_q.push_back({1'b1, c});
			return;
		end
		endcase
		// one byte closes the token, the next is swallowed on the way back to start
		repeat ($urandom_range(1, 2)) put(pick(" \t\n;"));
	endtask

	// Offer one transaction after a random gap and record what it must produce
	task automatic send_item(input logic restart, input logic [7:0] ch, input logic typed,
			input step_result_t want);
		int gap;
		step_result_t predicted;
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (drain_req && gap == 0)
			gap = 1;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain_req && expected_q.size() != 0) @(posedge clk);
			drain_req = 1'b0;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= restart;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = lex_step(restart, ch);
		expected_q.push_back(typed ? want : predicted);
		sent++;
	endtask

	task automatic report(input string field, input int want, input int got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// Stimulus: directed table first, then random token streams
	initial begin : stimulus
		logic [8:0] item;
		dir_rows = '{
			{1'b0, 8'hFF,     1'b1, ST_ERROR, 1'b0, 1'b1, TC_NONE},  // high byte from start
			{1'b0, "a",       1'b1, ST_ERROR, 1'b0, 1'b1, TC_NONE},  // error holds
			{1'b1, 8'hFF,     1'b1, ST_START, 1'b0, 1'b0, TC_NONE},  // restart ignores byte
			{1'b0, CH_NUL,    1'b1, ST_EOF,   1'b0, 1'b0, TC_NONE},
			{1'b0, "x",       1'b1, AC_EOF,   1'b1, 1'b0, TC_EOF},
			{1'b0, " ",       1'b0, NO_CHECK},                       // byte swallowed
			{1'b0, "%",       1'b0, NO_CHECK},
			{1'b0, 8'h80,     1'b0, NO_CHECK},                       // lone operator accepts
			{1'b0, "q",       1'b0, NO_CHECK},
			{1'b0, CH_QUOTE,  1'b0, NO_CHECK},
			{1'b0, CH_BSLASH, 1'b0, NO_CHECK},
			{1'b0, "x",       1'b0, NO_CHECK},                       // hex escape
			{1'b0, CH_BSLASH, 1'b0, NO_CHECK},
			{1'b0, "7",       1'b0, NO_CHECK},                       // octal escape
			{1'b0, 8'hC3,     1'b0, NO_CHECK},                       // high byte in body
			{1'b0, CH_QUOTE,  1'b0, NO_CHECK},
			{1'b0, "z",       1'b0, NO_CHECK},
			{1'b0, " ",       1'b0, NO_CHECK},
			{1'b0, CH_TAB,    1'b0, NO_CHECK},
			{1'b0, " ",       1'b0, NO_CHECK},
			{1'b0, "k",       1'b0, NO_CHECK},                       // end of blank run
			{1'b0, CH_QUOTE,  1'b0, NO_CHECK},
			{1'b0, CH_LF,     1'b1, ST_ERROR, 1'b0, 1'b1, TC_NONE},  // newline in string
			{1'b1, CH_NUL,    1'b1, ST_START, 1'b0, 1'b0, TC_NONE},
			{1'b0, "^",       1'b0, NO_CHECK}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_item(dir_rows[i].restart, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
		while (sent < N_ITEMS) begin
			if (sent == 600)
				long_hold_req = 1'b1;
			if (sent == 1000)
				drain_req = 1'b1;
			if (text_q.size() == 0)
				compose_token();
			item = text_q.pop_front();
			send_item(item[8], item[7:0], 1'b0, NO_CHECK);
		end
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random stalls, calm stretches and one long hold-off
	initial begin : receiver
		int stall;
		bit rx_calm;
		rx_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				stall = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0)
					rx_calm = !rx_calm;
				stall = rx_calm ? 0 : $urandom_range(0, 16);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		step_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual state %0d",
					$time, m_tdata[6:0]);
			end else begin
				want = expected_q.pop_front();
				if (m_tdata[6:0] !== want.state_code)
					report("state_code", want.state_code, m_tdata[6:0]);
				if (m_tuser[0] !== want.accepting)
					report("accepting", want.accepting, m_tuser[0]);
				if (m_tuser[1] !== want.is_error)
					report("is_error", want.is_error, m_tuser[1]);
				if (m_tuser[4:2] !== want.token_class)
					report("token_class", want.token_class, m_tuser[4:2]);
				if (m_tdata[7] !== 1'b0)
					report("tdata pad bit", 0, m_tdata[7]);
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

[filelist.f]
rtl/core/ctok_pkg.sv
rtl/core/ctok_classify.sv
rtl/core/ctok_next.sv
rtl/core/c_token_recognizer_dfa.sv
sim/tb_c_token_recognizer_dfa.sv
